/* rtl/edlk_pkg.sv */
// ----------------------------------------------------------------------------
// edlk_pkg
// Shared types and constants for the detent level knob.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edlk_pkg;

  // Field widths
  localparam int CountW   = 32;
  localparam int TimeW    = 32;
  localparam int LevelW   = 8;
  localparam int CpdW     = 5;
  localparam int ProdW    = 17;   // 256 * 255 fits in 17 bits
  localparam int SatW     = 9;    // detent count saturated at 256

  // Stream widths
  localparam int InDataW  = 72;   // raw_count, now_ms, level_in
  localparam int OutDataW = 16;   // level_out, level_changed, save_pulse, pad
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_LEVEL_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_STEP = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IDLE_MS    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CPD        = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SAVE_EN    = 3'd5;

  // Register reset values
  localparam logic [LevelW-1:0] RST_LEVEL_MIN  = 8'd0;
  localparam logic [LevelW-1:0] RST_LEVEL_MAX  = 8'd255;
  localparam logic [LevelW-1:0] RST_LEVEL_STEP = 8'd1;
  localparam logic [TimeW-1:0]  RST_IDLE_MS    = 32'd2000;
  localparam logic [CpdW-1:0]   RST_CPD        = 5'd4;

  // Divider response back to the sequencer
  typedef struct packed {
    logic              done;
    logic [CountW-1:0] quot;
    logic [CpdW-1:0]   rem;
  } div_rsp_t;

endpackage

/* rtl/edlk_div.sv */
// ----------------------------------------------------------------------------
// edlk_div
// Serial restoring divider, 32-bit magnitude by 5-bit divisor, two bits
// per cycle. Result is valid with a one-cycle done pulse once the last bits are in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edlk_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [edlk_pkg::CountW-1:0] dividend,
  input  logic [edlk_pkg::CpdW-1:0]   divisor,
  output edlk_pkg::div_rsp_t          rsp
);
  import edlk_pkg::*;

  localparam int BitsPerCyc = 2;
  localparam int Iters      = CountW / BitsPerCyc;
  localparam int CntW       = $clog2(Iters);

  logic [CountW-1:0] dvd_r, dvd_nxt;
  logic [CpdW-1:0]   dvs_r;
  logic [CpdW-1:0]   rem_r, rem_nxt;
  logic [CntW-1:0]   cnt_r;
  logic              busy_r;
  logic              done_r;

  // Two restoring steps per cycle
  always_comb begin
    logic [CpdW:0] trial;
    trial   = '0;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int k = 0; k < BitsPerCyc; k++) begin
      trial   = {rem_nxt, dvd_nxt[CountW-1]};
      dvd_nxt = {dvd_nxt[CountW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        dvd_nxt[0] = 1'b1;
      end
      rem_nxt = trial[CpdW-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(Iters - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

/* rtl/encoder_detent_level_knob.sv */
// ----------------------------------------------------------------------------
// encoder_detent_level_knob
// Turns raw quadrature polls into whole-detent level steps with clamping and
// an idle save pulse.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per poll; tdata = {level_in, now_ms, raw_count}.
//   out_* : exactly one beat per poll; tdata = {pad, save_pulse,
//           level_changed, level_out}.
//   cfg_* : register writes (index, data), always ready; write only while
//           no poll is in flight.
// Steps from input beat to output beat: difference, divider start, divider
//   iterations at two quotient bits each, done, multiply, finish.
// Polls do not overlap: in_tready is low while a poll is being worked on
//   and comes back with the result.
// A stalled receiver holds the result in the output register; a finished
//   poll waits in the finish step until that register is free.
// Reset: registers return to their defaults, consumed count, last turn time
//   and the unsaved mark clear; no output beat is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_detent_level_knob (
  input  logic                          clk,
  input  logic                          rst_n,
  // tdata: [31:0] raw_count, [63:32] now_ms, [71:64] level_in
  input  logic [edlk_pkg::InDataW-1:0]  in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: [7:0] level_out, [8] level_changed, [9] save_pulse, [15:10] zero
  output logic [edlk_pkg::OutDataW-1:0] out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [edlk_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [edlk_pkg::CfgDataW-1:0] cfg_data
);
  import edlk_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  // Config registers
  logic [LevelW-1:0] lvl_min_r, lvl_max_r, lvl_step_r;
  logic [TimeW-1:0]  idle_ms_r;
  logic [CpdW-1:0]   cpd_r;
  logic              save_en_r;

  // Persistent state
  logic [CountW-1:0] consumed_r, consumed_nxt;
  logic              pending_r, pending_nxt;
  logic [TimeW-1:0]  last_ms_r, last_ms_nxt;

  // Sequencer and per-poll working registers
  logic [2:0]        state_r;
  logic [CountW-1:0] raw_r;
  logic [TimeW-1:0]  now_r;
  logic [LevelW-1:0] lvl_in_r;
  logic [CountW-1:0] diff_r;
  logic              neg;
  logic [CountW-1:0] mag;
  logic [SatW-1:0]   sat_r;
  logic              moved_r;
  logic [CpdW-1:0]   rem_r;
  logic [ProdW-1:0]  prod_r;

  // Output register
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic                out_valid_r;
  logic                out_free;

  // Divider
  logic              div_start;
  logic [CpdW-1:0]   cpd_eff;
  div_rsp_t          div_rsp;

  // Finish-step values
  logic [CountW-1:0] rem_signed;
  logic signed [ProdW:0] sum;
  logic signed [ProdW:0] clamped;
  logic [LevelW-1:0] lvl_out;
  logic [TimeW-1:0]  quiet;
  logic              save;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign cpd_eff   = (cpd_r == '0) ? CpdW'(1) : cpd_r;
  assign neg       = diff_r[CountW-1];
  assign mag       = neg ? (~diff_r + 1'b1) : diff_r;
  assign div_start = (state_r == ST_START);

  edlk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (cpd_eff),
    .rsp      (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_min_r  <= RST_LEVEL_MIN;
      lvl_max_r  <= RST_LEVEL_MAX;
      lvl_step_r <= RST_LEVEL_STEP;
      idle_ms_r  <= RST_IDLE_MS;
      cpd_r      <= RST_CPD;
      save_en_r  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEVEL_MIN:  lvl_min_r  <= cfg_data[LevelW-1:0];
        REG_LEVEL_MAX:  lvl_max_r  <= cfg_data[LevelW-1:0];
        REG_LEVEL_STEP: lvl_step_r <= cfg_data[LevelW-1:0];
        REG_IDLE_MS:    idle_ms_r  <= cfg_data[TimeW-1:0];
        REG_CPD:        cpd_r      <= cfg_data[CpdW-1:0];
        REG_SAVE_EN:    save_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Finish step: consume whole detents, clamp, idle save
  always_comb begin
    rem_signed = neg ? (~{{(CountW-CpdW){1'b0}}, rem_r} + 1'b1)
                     : {{(CountW-CpdW){1'b0}}, rem_r};
    sum = neg ? ($signed({1'b0, {(ProdW-LevelW){1'b0}}, lvl_in_r}) -
                 $signed({1'b0, prod_r}))
              : ($signed({1'b0, {(ProdW-LevelW){1'b0}}, lvl_in_r}) +
                 $signed({1'b0, prod_r}));
    clamped = sum;
    if (clamped < $signed({1'b0, {(ProdW-LevelW){1'b0}}, lvl_min_r}))
      clamped = $signed({1'b0, {(ProdW-LevelW){1'b0}}, lvl_min_r});
    if (clamped > $signed({1'b0, {(ProdW-LevelW){1'b0}}, lvl_max_r}))
      clamped = $signed({1'b0, {(ProdW-LevelW){1'b0}}, lvl_max_r});

    consumed_nxt = consumed_r;
    pending_nxt  = pending_r;
    last_ms_nxt  = last_ms_r;
    lvl_out      = lvl_in_r;
    if (moved_r) begin
      consumed_nxt = raw_r - rem_signed;
      pending_nxt  = 1'b1;
      last_ms_nxt  = now_r;
      lvl_out      = clamped[LevelW-1:0];
    end

    quiet = now_r - last_ms_nxt;
    save  = 1'b0;
    if (pending_nxt && (quiet > idle_ms_r)) begin
      save        = save_en_r;
      pending_nxt = 1'b0;
    end

    out_data_nxt = {{(OutDataW-LevelW-2){1'b0}}, save, (lvl_out != lvl_in_r), lvl_out};
  end

  // Sequencer and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      consumed_r  <= '0;
      pending_r   <= 1'b0;
      last_ms_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready)
        out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE:  if (in_tvalid) state_r <= ST_START;
        ST_START: state_r <= ST_DIV;
        ST_DIV:   if (div_rsp.done) state_r <= ST_MUL;
        ST_MUL:   state_r <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            consumed_r  <= consumed_nxt;
            pending_r   <= pending_nxt;
            last_ms_r   <= last_ms_nxt;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      raw_r    <= in_tdata[CountW-1:0];
      now_r    <= in_tdata[CountW+TimeW-1:CountW];
      lvl_in_r <= in_tdata[CountW+TimeW+LevelW-1:CountW+TimeW];
      diff_r   <= in_tdata[CountW-1:0] - consumed_r;
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      sat_r   <= (div_rsp.quot[CountW-1:SatW-1] != '0) ? SatW'(256)
                                                     : div_rsp.quot[SatW-1:0];
      moved_r <= (div_rsp.quot != '0);
      rem_r   <= div_rsp.rem;
    end
    if (state_r == ST_MUL)
      prod_r <= {{(ProdW-SatW){1'b0}}, sat_r} * {{(ProdW-LevelW){1'b0}}, lvl_step_r};
    if (state_r == ST_FIN && out_free)
      out_data_r <= out_data_nxt;
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

/* rtl/edlk_chk.sv */
// ----------------------------------------------------------------------------
// edlk_chk
// Port-level checks for the detent level knob, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edlk_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [edlk_pkg::OutDataW-1:0] out_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready
);
  import edlk_pkg::*;

  // Reset leaves the block ready with no beat pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("edlk: not idle after reset");

  // An accepted poll keeps the input closed through the start and divide states
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("edlk: input reopened too early");

  // A new result arrives together with the input reopening
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready && !$past(in_tready))
    else $error("edlk: result without return to idle");

  // A turn restamps the time, so no save in the same poll
  a_no_save_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[LevelW] && out_tdata[LevelW+1]))
    else $error("edlk: save pulse on a turning poll");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("edlk: output beat changed while stalled");

endmodule

bind encoder_detent_level_knob edlk_chk u_edlk_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
